// ===== rtl/core/lpd_pkg.sv =====
// Shared types and constants for the length-prefixed deframer.
// Used by lpd_step, lpd_out_reg and length_prefixed_deframer_unit; no dependencies.
`default_nettype none

package lpd_pkg;

  localparam int unsigned PrefixBytesDefault = 4;
  localparam int unsigned ByteW              = 8;
  localparam int unsigned LenW               = 32;
  localparam int unsigned TypeW              = 2;

  // Header byte layout.
  localparam int unsigned HdrCompBit = 0;
  localparam int unsigned HdrTypeLsb = 1;

  typedef enum logic [2:0] {
    PhLength = 3'b001,
    PhHeader = 3'b010,
    PhBody   = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [LenW-1:0]   len;
    logic              comp;
    logic [TypeW-1:0]  ptype;
  } state_t;

  typedef struct packed {
    logic [ByteW-1:0]  payload_byte;
    logic              compressed_flag;
    logic [TypeW-1:0]  packet_type;
    logic              last_of_packet;
    logic              empty_packet;
    logic              bad_length;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/length_prefixed_deframer_unit.sv =====
// Top level of the length-prefixed deframer: input register, deframing state
// and result register. Depends on lpd_pkg, lpd_step and lpd_out_reg.
`default_nettype none

//   Channel | Direction | Handshake              | Payload
//   rx      | in        | rx_valid_i / rx_stall_o | rx_byte_i
//   out     | out       | out_valid_o / out_stall_i | payload_byte_o .. bad_length_o
//
// Each byte is held in the input register and is then processed in a single
// pass against the deframing state; a result, if any, is loaded into the
// output register once it has room, so one byte is taken every cycle while the
// result side keeps up. Reset returns the machine to collecting the first length
// byte. A stalled result holds the waiting byte only if that byte would itself
// produce a result; bytes that produce none still move through.

module length_prefixed_deframer_unit import lpd_pkg::*; #(
  parameter int unsigned PREFIX_BYTES = PrefixBytesDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [ByteW-1:0] rx_byte_i,
  input  wire logic             rx_valid_i,
  output logic                  rx_stall_o,
  output logic [ByteW-1:0]      payload_byte_o,
  output logic                  compressed_flag_o,
  output logic [TypeW-1:0]      packet_type_o,
  output logic                  last_of_packet_o,
  output logic                  empty_packet_o,
  output logic                  bad_length_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i
);

  localparam int unsigned CntW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1;

  // Input register: one received byte awaiting processing.
  logic [ByteW-1:0] in_byte_q;
  logic             in_vld_q, in_vld_d;

  // Deframing state.
  state_t          st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic    res_vld;
  result_t res;
  result_t res_out;
  logic    out_free;
  logic    advance;
  logic    rx_take;

  lpd_step #(
    .PREFIX_BYTES (PREFIX_BYTES),
    .CntW         (CntW)
  ) u_step (
    .byte_i    (in_byte_q),
    .st_i      (st_q),
    .cnt_i     (cnt_q),
    .st_o      (st_d),
    .cnt_o     (cnt_d),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // The held byte moves on when it produces no result or the output has room.
  assign advance    = in_vld_q && (!res_vld || out_free);
  assign rx_stall_o = in_vld_q && !advance;
  assign rx_take    = rx_valid_i && !rx_stall_o;
  assign in_vld_d   = rx_take || (in_vld_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      st_q     <= '{phase: PhLength, len: '0, comp: 1'b0, ptype: '0};
      cnt_q    <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (advance) begin
        st_q  <= st_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  lpd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_vld),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (res_out)
  );

  assign payload_byte_o    = res_out.payload_byte;
  assign compressed_flag_o = res_out.compressed_flag;
  assign packet_type_o     = res_out.packet_type;
  assign last_of_packet_o  = res_out.last_of_packet;
  assign empty_packet_o    = res_out.empty_packet;
  assign bad_length_o      = res_out.bad_length;

endmodule

`default_nettype wire

// ===== rtl/core/lpd_step.sv =====
// Combinational next-state and result logic for one received byte.
// Depends on lpd_pkg.
`default_nettype none

module lpd_step import lpd_pkg::*; #(
  parameter int unsigned PREFIX_BYTES = PrefixBytesDefault,
  parameter int unsigned CntW = (PREFIX_BYTES > 1) ? $clog2(PREFIX_BYTES) : 1
) (
  input  wire logic [ByteW-1:0] byte_i,
  input  wire state_t           st_i,
  input  wire logic [CntW-1:0]  cnt_i,
  output state_t                st_o,
  output logic      [CntW-1:0]  cnt_o,
  output logic                  res_vld_o,
  output result_t               res_o
);

  localparam logic [CntW-1:0] CntLast = CntW'(PREFIX_BYTES - 1);

  logic [LenW-1:0] base;
  logic [LenW-1:0] shifted;
  logic            body_last;

  always_comb begin
    base      = (cnt_i == '0) ? '0 : st_i.len;
    shifted   = {base[LenW-ByteW-1:0], byte_i};
    body_last = (st_i.len <= LenW'(1));

    st_o      = st_i;
    cnt_o     = cnt_i;
    res_vld_o = 1'b0;
    res_o     = '0;

    unique case (st_i.phase)
      PhHeader: begin
        st_o.comp  = byte_i[HdrCompBit];
        st_o.ptype = byte_i[HdrTypeLsb +: TypeW];
        if (st_i.len == '0) begin
          res_vld_o             = 1'b1;
          res_o.compressed_flag = byte_i[HdrCompBit];
          res_o.packet_type     = byte_i[HdrTypeLsb +: TypeW];
          res_o.last_of_packet  = 1'b1;
          res_o.empty_packet    = 1'b1;
          st_o.phase            = PhLength;
          cnt_o                 = '0;
        end else begin
          st_o.phase = PhBody;
        end
      end
      PhBody: begin
        res_vld_o             = 1'b1;
        res_o.payload_byte    = byte_i;
        res_o.compressed_flag = st_i.comp;
        res_o.packet_type     = st_i.ptype;
        res_o.last_of_packet  = body_last;
        if (st_i.len != '0) begin
          st_o.len = st_i.len - LenW'(1);
        end
        if (body_last) begin
          st_o.phase = PhLength;
          cnt_o      = '0;
        end
      end
      default: begin
        // Length collection; an illegal phase code is treated the same way.
        st_o.phase = PhLength;
        if (cnt_i == CntLast) begin
          cnt_o = '0;
          if (shifted == '0) begin
            res_vld_o        = 1'b1;
            res_o.bad_length = 1'b1;
            st_o.len         = shifted;
          end else begin
            st_o.len   = shifted - LenW'(1);
            st_o.phase = PhHeader;
          end
        end else begin
          st_o.len = shifted;
          cnt_o    = cnt_i + CntW'(1);
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/lpd_out_reg.sv =====
// Output result register with valid/stall handshake.
// Depends on lpd_pkg.
`default_nettype none

module lpd_out_reg import lpd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         free_o,
  output logic         valid_o,
  input  wire logic    stall_i,
  output result_t      res_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  assign free_o  = !vld_q || !stall_i;
  assign vld_d   = load_i || (vld_q && stall_i);
  assign valid_o = vld_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire
